>>> design/iise_pkg.sv
// Shared constants, types and helpers for the int8 index score engine.
package iise_pkg;

    // Geometry
    localparam int HEADS    = 64;
    localparam int HEAD_DIM = 128;
    localparam int HEAD_W   = (HEADS > 1) ? $clog2(HEADS) : 1;
    localparam int QA_W     = $clog2(HEADS * HEAD_DIM);

    // Word field widths
    localparam int OP_W    = 2;
    localparam int HFLD_W  = 6;
    localparam int DIM_W   = 7;
    localparam int BYTE_W  = 8;
    localparam int COEF_W  = 32;
    localparam int SCORE_W = 64;

    // Head accumulator range
    localparam int ACC_W   = 22;
    localparam int MAC_W   = ACC_W + 1;
    localparam logic signed [MAC_W-1:0] ACC_MAX = MAC_W'((1 << (ACC_W - 1)) - 1);
    localparam logic signed [MAC_W-1:0] ACC_MIN = -MAC_W'(1 << (ACC_W - 1));

    // Score datapath widths
    localparam int D_W    = COEF_W + ACC_W;          // scale * acc
    localparam int DLO_W  = 27;                      // low slice of positive d
    localparam int DHI_W  = D_W - 1 - DLO_W;         // high slice of positive d
    localparam int PLO_W  = DLO_W + 1 + COEF_W;
    localparam int PHI_W  = DHI_W + 1 + COEF_W;
    localparam int P_W    = PHI_W + DLO_W + 1;
    localparam int SUM_W  = P_W + HEAD_W;

    // Word opcodes
    typedef enum logic [OP_W-1:0] {
        OP_QUERY  = 2'd0,
        OP_SCALE  = 2'd1,
        OP_WEIGHT = 2'd2,
        OP_KEY    = 2'd3
    } t_op;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // One head's contribution entering the score pipe
    typedef struct packed {
        logic                     vld;
        logic signed [ACC_W-1:0]  acc;
        logic signed [COEF_W-1:0] scale;
        logic signed [COEF_W-1:0] weight;
    } t_score_in;

    // Score pipe status
    typedef struct packed {
        logic busy;
    } t_score_stat;

    // Clamp the wide row sum to the signed 64-bit score range
    function automatic logic signed [SCORE_W-1:0] sat_score(
        input logic signed [SUM_W-1:0] sum
    );
        logic [SUM_W-SCORE_W:0] top;
        top = sum[SUM_W-1:SCORE_W-1];
        if ((top == '0) || (top == '1)) begin
            return sum[SCORE_W-1:0];
        end else if (sum[SUM_W-1]) begin
            return {1'b1, {(SCORE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SCORE_W-1){1'b1}}};
        end
    endfunction

endpackage

>>> design/iise_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module iise_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/iise_head_mac.sv
// Per-head multiply-accumulate with saturation to the accumulator range.
module iise_head_mac (
    input  logic signed [iise_pkg::BYTE_W-1:0] i_query,
    input  logic signed [iise_pkg::BYTE_W-1:0] i_key,
    input  logic signed [iise_pkg::ACC_W-1:0]  i_acc,
    input  logic                               i_acc_vld,
    output logic signed [iise_pkg::ACC_W-1:0]  o_acc
);
    import iise_pkg::*;

    logic signed [2*BYTE_W-1:0] w_prod;
    logic signed [MAC_W-1:0]    w_base;
    logic signed [MAC_W-1:0]    w_sum;

    // Entry not written since the last row end reads as zero
    assign w_prod = (2*BYTE_W)'(i_query) * (2*BYTE_W)'(i_key);
    assign w_base = i_acc_vld ? MAC_W'(i_acc) : '0;
    assign w_sum  = w_base + MAC_W'(w_prod);

    // Clamp to signed accumulator range
    always_comb begin
        if (w_sum > ACC_MAX) begin
            o_acc = ACC_MAX[ACC_W-1:0];
        end else if (w_sum < ACC_MIN) begin
            o_acc = ACC_MIN[ACC_W-1:0];
        end else begin
            o_acc = w_sum[ACC_W-1:0];
        end
    end

endmodule

>>> design/iise_score_pipe.sv
// Row-end score pipeline: scale, relu, weight and wide sum over heads.
module iise_score_pipe (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_clear,
    input  iise_pkg::t_score_in                i_in,
    output logic signed [iise_pkg::SUM_W-1:0]  o_sum,
    output iise_pkg::t_score_stat              o_stat
);
    import iise_pkg::*;

    logic                     r_v2, r_v3, r_v4, r_v5;
    logic signed [ACC_W-1:0]  r_a2;
    logic signed [COEF_W-1:0] r_sc2, r_w2, r_w3;
    logic signed [D_W-1:0]    r_d3;
    logic signed [PLO_W-1:0]  r_plo4;
    logic signed [PHI_W-1:0]  r_phi4;
    logic signed [P_W-1:0]    r_p5;
    logic signed [SUM_W-1:0]  r_sum;

    logic signed [D_W-1:0]    w_d;
    logic                     w_pos;
    logic signed [DLO_W:0]    w_dlo;
    logic signed [DHI_W:0]    w_dhi;
    logic signed [PLO_W-1:0]  w_plo;
    logic signed [PHI_W-1:0]  w_phi;
    logic signed [P_W-1:0]    w_p;

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v2 <= i_in.vld;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Scale times accumulator
    assign w_d = D_W'(r_sc2) * D_W'(r_a2);

    // Relu, then split the positive product for two narrow weight multiplies
    assign w_pos = !r_d3[D_W-1] && (r_d3 != '0);
    assign w_dlo = $signed({1'b0, r_d3[DLO_W-1:0]});
    assign w_dhi = $signed({1'b0, r_d3[D_W-2:DLO_W]});
    assign w_plo = w_pos ? PLO_W'(w_dlo) * PLO_W'(r_w3) : '0;
    assign w_phi = w_pos ? PHI_W'(w_dhi) * PHI_W'(r_w3) : '0;

    // Recombine partial products
    assign w_p = (P_W'(r_phi4) <<< DLO_W) + P_W'(r_plo4);

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_a2   <= i_in.acc;
        r_sc2  <= i_in.scale;
        r_w2   <= i_in.weight;
        r_d3   <= w_d;
        r_w3   <= r_w2;
        r_plo4 <= w_plo;
        r_phi4 <= w_phi;
        r_p5   <= w_p;
    end

    // Row sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_sum <= '0;
        end else if (r_v5) begin
            r_sum <= r_sum + SUM_W'(r_p5);
        end
    end

    assign o_sum       = r_sum;
    assign o_stat.busy = r_v2 | r_v3 | r_v4 | r_v5;

endmodule

>>> design/int8_index_score_engine_core.sv
// Top level of the int8 index score engine: word decode, head sequencer, memories.
//
// Input channel (i_valid / o_ready) takes one word per handshake. Opcode i_op
// selects a query byte load (i_head, i_dim, i_byte_value), a head scale or
// weight load (i_head, i_coeff, Q.24), or a key byte (i_dim, i_byte_value).
// Loads finish in the cycle they are taken, so they stream at one per cycle.
// A key byte walks all HEADS heads through the accumulator RAM, one head per
// cycle (read, MAC, write back). The key byte at dimension HEAD_DIM-1 instead
// feeds each updated head into the score pipe; once the pipe drains, the score
// is emitted and the engine returns to idle for the next word.
// Output channel (o_valid / i_ready) carries one Q.48 saturated o_score word
// per key row. The score sits in an output register; the engine keeps taking
// words while it waits, and only stalls at the next row end if the previous
// score has still not been taken.
// Reset clears the sequencer, the accumulator valid bits (so all head
// accumulators read as zero) and the output valid flag. Query, scale and weight
// memories hold no reset value and must be loaded before use.
module int8_index_score_engine_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [iise_pkg::OP_W-1:0]             i_op,
    input  logic [iise_pkg::HFLD_W-1:0]           i_head,
    input  logic [iise_pkg::DIM_W-1:0]            i_dim,
    input  logic signed [iise_pkg::BYTE_W-1:0]    i_byte_value,
    input  logic signed [iise_pkg::COEF_W-1:0]    i_coeff,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [iise_pkg::SCORE_W-1:0]   o_score
);
    import iise_pkg::*;

    t_state                    r_state, n_state;
    logic [HEAD_W-1:0]         r_cnt;
    logic [DIM_W-1:0]          r_dim;
    logic signed [BYTE_W-1:0]  r_key;
    logic                      r_fin;
    logic                      r_v1;
    logic [HEAD_W-1:0]         r_h1;
    logic [HEADS-1:0]          r_acc_vld;
    logic                      r_out_vld;
    logic signed [SCORE_W-1:0] r_score;

    logic              w_accept;
    logic              w_head_ok;
    logic              w_q_we, w_s_we, w_w_we, w_key_go;
    logic              w_issue;
    logic              w_emit;
    logic              w_last;
    logic [QA_W-1:0]   w_q_waddr, w_q_raddr;
    logic [BYTE_W-1:0] w_q_rdata;
    logic [COEF_W-1:0] w_s_rdata, w_w_rdata;
    logic [ACC_W-1:0]  w_acc_rdata;
    logic signed [ACC_W-1:0] w_acc_new;
    logic              w_acc_we;
    logic signed [SUM_W-1:0] w_sum;
    t_score_in         w_score_in;
    t_score_stat       w_score_stat;

    // Word decode
    assign w_accept  = i_valid && o_ready;
    assign w_head_ok = int'(i_head) < HEADS;

    always_comb begin
        w_q_we   = 1'b0;
        w_s_we   = 1'b0;
        w_w_we   = 1'b0;
        w_key_go = 1'b0;
        unique case (t_op'(i_op))
            OP_QUERY:  w_q_we   = w_accept && w_head_ok && (int'(i_dim) < HEAD_DIM);
            OP_SCALE:  w_s_we   = w_accept && w_head_ok;
            OP_WEIGHT: w_w_we   = w_accept && w_head_ok;
            OP_KEY:    w_key_go = w_accept && (int'(i_dim) < HEAD_DIM);
            default:   w_key_go = 1'b0;
        endcase
    end

    assign w_last = (r_cnt == HEAD_W'(HEADS - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_key_go) n_state = ST_ISSUE;
            ST_ISSUE: if (w_last) n_state = ST_DRAIN;
            ST_DRAIN: begin
                if (!r_v1 && !w_score_stat.busy) n_state = r_fin ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:  if (!r_out_vld || i_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_ready = 1'b0;
        w_issue = 1'b0;
        w_emit  = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_ready = 1'b1;
            ST_ISSUE: w_issue = 1'b1;
            ST_DRAIN: w_issue = 1'b0;
            ST_EMIT:  w_emit  = !r_out_vld || i_ready;
            default:  o_ready = 1'b0;
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_fin   <= 1'b0;
            r_v1    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_issue;
            if (w_key_go) begin
                r_cnt <= '0;
                r_fin <= (int'(i_dim) == HEAD_DIM - 1);
            end else if (w_issue && !w_last) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Key word and head tag of the read in flight
    always_ff @(posedge i_clk) begin
        if (w_key_go) begin
            r_dim <= i_dim;
            r_key <= i_byte_value;
        end
        r_h1 <= r_cnt;
    end

    // Memory addresses
    assign w_q_waddr = QA_W'(int'(i_head) * HEAD_DIM + int'(i_dim));
    assign w_q_raddr = QA_W'(int'(r_cnt) * HEAD_DIM + int'(r_dim));

    iise_ram #(.WIDTH(BYTE_W), .DEPTH(HEADS * HEAD_DIM)) u_query_ram (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (w_q_waddr),
        .i_wdata (i_byte_value),
        .i_raddr (w_q_raddr),
        .o_rdata (w_q_rdata)
    );

    iise_ram #(.WIDTH(COEF_W), .DEPTH(HEADS)) u_scale_ram (
        .i_clk   (i_clk),
        .i_we    (w_s_we),
        .i_waddr (i_head[HEAD_W-1:0]),
        .i_wdata (i_coeff),
        .i_raddr (r_cnt),
        .o_rdata (w_s_rdata)
    );

    iise_ram #(.WIDTH(COEF_W), .DEPTH(HEADS)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_w_we),
        .i_waddr (i_head[HEAD_W-1:0]),
        .i_wdata (i_coeff),
        .i_raddr (r_cnt),
        .o_rdata (w_w_rdata)
    );

    iise_ram #(.WIDTH(ACC_W), .DEPTH(HEADS)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc_we),
        .i_waddr (r_h1),
        .i_wdata (w_acc_new),
        .i_raddr (r_cnt),
        .o_rdata (w_acc_rdata)
    );

    // Read-modify-write of one head accumulator per cycle
    iise_head_mac u_mac (
        .i_query   ($signed(w_q_rdata)),
        .i_key     (r_key),
        .i_acc     ($signed(w_acc_rdata)),
        .i_acc_vld (r_acc_vld[r_h1]),
        .o_acc     (w_acc_new)
    );

    assign w_acc_we = r_v1 && !r_fin;

    // Accumulator valid bits: set on write back, all cleared at row end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_emit) begin
            r_acc_vld <= '0;
        end else if (w_acc_we) begin
            r_acc_vld[r_h1] <= 1'b1;
        end
    end

    // Row end: updated heads go to the score pipe instead of back to memory
    assign w_score_in.vld    = r_v1 && r_fin;
    assign w_score_in.acc    = w_acc_new;
    assign w_score_in.scale  = $signed(w_s_rdata);
    assign w_score_in.weight = $signed(w_w_rdata);

    iise_score_pipe u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_key_go),
        .i_in    (w_score_in),
        .o_sum   (w_sum),
        .o_stat  (w_score_stat)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_emit) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_score <= sat_score(w_sum);
        end
    end

    assign o_valid = r_out_vld;
    assign o_score = r_score;

    // Words are only taken with the head pipeline empty
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (!r_v1 && !w_score_stat.busy))
        else $error("word accepted while head pipeline busy");

    // Score pipe only runs for a row-closing key byte
    a_score_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_score_stat.busy |-> r_fin)
        else $error("score pipe active outside a row end");

    // Accumulators read as zero after a score is emitted
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_acc_vld == '0) && o_valid)
        else $error("accumulators not cleared at row end");

    // Memory reads return only while a key byte is being walked
    a_read_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (r_state == ST_ISSUE || r_state == ST_DRAIN))
        else $error("head read returned outside a key pass");

endmodule

>>> tb/sv/iise_tb_pkg.sv
`timescale 1ns / 100ps
// Row score predictor and result checker for the int8 index score engine testbench.
package iise_tb_pkg;
    import iise_pkg::*;

    // Head accumulator clamp and final score clamp
    localparam int ACC_TOP = (1 << (ACC_W - 1)) - 1;
    localparam int ACC_BOT = -(1 << (ACC_W - 1));
    localparam logic signed [127:0] SCORE_TOP = 128'sh7fff_ffff_ffff_ffff;
    localparam logic signed [127:0] SCORE_BOT = -SCORE_TOP - 128'sd1;

    class row_scorer;
        logic signed [BYTE_W-1:0]  query_mem [HEADS*HEAD_DIM];
        logic signed [COEF_W-1:0]  scale_mem [HEADS];
        logic signed [COEF_W-1:0]  weight_mem [HEADS];
        int                        head_acc [HEADS];
        logic signed [SCORE_W-1:0] pending_scores [$];
        int                        mismatches;
        int                        scores_seen;

        function new();
            mismatches  = 0;
            scores_seen = 0;
            foreach (head_acc[h]) head_acc[h] = 0;
        endfunction

        // Sum of relu(scale * acc) * weight over heads, exact, then clamped to 64 bits
        function logic signed [SCORE_W-1:0] row_score();
            logic signed [127:0] total;
            logic signed [127:0] d;
            logic signed [127:0] w;
            total = '0;
            for (int h = 0; h < HEADS; h++) begin
                d = scale_mem[h];
                d = d * head_acc[h];
                w = weight_mem[h];
                if (d > 0 && w != 0) total = total + d * w;
            end
            if (total > SCORE_TOP) total = SCORE_TOP;
            if (total < SCORE_BOT) total = SCORE_BOT;
            return total[SCORE_W-1:0];
        endfunction

        // Apply one accepted input word; a key byte on the last dimension queues a score
        function void take_word(t_op op, logic [HFLD_W-1:0] head, logic [DIM_W-1:0] dim,
                                logic signed [BYTE_W-1:0] b,
                                logic signed [COEF_W-1:0] coeff);
            int a;
            case (op)
                OP_QUERY: begin
                    if (head < HEADS && dim < HEAD_DIM)
                        query_mem[int'(head) * HEAD_DIM + int'(dim)] = b;
                end
                OP_SCALE: begin
                    if (head < HEADS) scale_mem[head] = coeff;
                end
                OP_WEIGHT: begin
                    if (head < HEADS) weight_mem[head] = coeff;
                end
                OP_KEY: begin
                    if (dim < HEAD_DIM) begin
                        for (int h = 0; h < HEADS; h++) begin
                            a = head_acc[h] +
                                int'(query_mem[h * HEAD_DIM + int'(dim)]) * int'(b);
                            if (a > ACC_TOP) a = ACC_TOP;
                            if (a < ACC_BOT) a = ACC_BOT;
                            head_acc[h] = a;
                        end
                        if (dim == HEAD_DIM - 1) begin
                            pending_scores.push_back(row_score());
                            foreach (head_acc[h]) head_acc[h] = 0;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        // Compare one output word with the oldest queued score
        function void check_score(logic signed [SCORE_W-1:0] got);
            logic signed [SCORE_W-1:0] want;
            scores_seen++;
            if (pending_scores.size() == 0) begin
                mismatches++;
                $display("%0t: score expected none, actual %0d", $time, got);
                return;
            end
            want = pending_scores.pop_front();
            if (got !== want) begin
                mismatches++;
                $display("%0t: score expected %0d, actual %0d", $time, want, got);
            end
        endfunction
    endclass

endpackage

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top-level testbench for the int8 index score engine core.
module tb_top;
    import iise_pkg::*;
    import iise_tb_pkg::*;

    localparam int WORD_TARGET = 1100;
    localparam int MIN_ROWS    = 40;
    localparam int POUND_LEN   = 140;
    localparam int MAX_POUNDS  = 3;
    localparam logic signed [COEF_W-1:0] COEF_TOP = 32'sh7fff_ffff;
    localparam logic signed [COEF_W-1:0] COEF_BOT = 32'sh8000_0000;
    localparam logic signed [BYTE_W-1:0] BYTE_TOP = 8'sh7f;
    localparam logic signed [BYTE_W-1:0] BYTE_BOT = 8'sh80;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic [OP_W-1:0]           i_op;
    logic [HFLD_W-1:0]         i_head;
    logic [DIM_W-1:0]          i_dim;
    logic signed [BYTE_W-1:0]  i_byte_value;
    logic signed [COEF_W-1:0]  i_coeff;
    logic                      o_valid;
    logic                      i_ready;
    logic signed [SCORE_W-1:0] o_score;

    row_scorer scorer;
    bit        calm;
    int        words_sent;
    int        rows_random;
    int        pound_rows;
    int        out_hold;
    // Dimensions whose query bytes are loaded for every head; keys only use these
    int        key_dims [4] = '{0, 42, 85, HEAD_DIM - 1};

    int8_index_score_engine_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_head       (i_head),
        .i_dim        (i_dim),
        .i_byte_value (i_byte_value),
        .i_coeff      (i_coeff),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_score      (o_score)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hang guard
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Idle length: mostly none or short, now and then long; none in a calm stretch
    function automatic int pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [BYTE_W-1:0] rand_byte();
        case ($urandom_range(0, 9))
            0:       return BYTE_BOT;
            1:       return BYTE_TOP;
            2:       return '0;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    // Mix of extremes, small values (so scores often stay unsaturated) and full range
    function automatic logic signed [COEF_W-1:0] rand_coeff();
        int unsigned        r;
        logic signed [20:0] small_c;
        r = $urandom_range(0, 99);
        small_c = 21'($urandom);
        if (r < 4) return COEF_TOP;
        if (r < 8) return COEF_BOT;
        if (r < 12) return '0;
        if (r < 55) return small_c;
        return COEF_W'($urandom);
    endfunction

    // Present one word and hold it until the handshake
    task automatic send_word(t_op op, logic [HFLD_W-1:0] head, logic [DIM_W-1:0] dim,
                             logic signed [BYTE_W-1:0] b, logic signed [COEF_W-1:0] coeff);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_op         <= op;
        i_head       <= head;
        i_dim        <= dim;
        i_byte_value <= b;
        i_coeff      <= coeff;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        scorer.take_word(op, head, dim, b, coeff);
        words_sent++;
    endtask

    // Fields a word does not use carry random values
    task automatic send_key(logic [DIM_W-1:0] dim, logic signed [BYTE_W-1:0] b);
        send_word(OP_KEY, HFLD_W'($urandom), dim, b, COEF_W'($urandom));
    endtask

    task automatic load_query(logic [HFLD_W-1:0] head, logic [DIM_W-1:0] dim,
                              logic signed [BYTE_W-1:0] b);
        send_word(OP_QUERY, head, dim, b, COEF_W'($urandom));
    endtask

    task automatic load_coef(t_op op, logic [HFLD_W-1:0] head, logic signed [COEF_W-1:0] c);
        send_word(op, head, DIM_W'($urandom), BYTE_W'($urandom), c);
    endtask

    task automatic random_load();
        t_op              op;
        logic [DIM_W-1:0] d;
        op = t_op'($urandom_range(0, 2));
        if (op == OP_QUERY) begin
            d = $urandom_range(0, 1) ? DIM_W'(key_dims[$urandom_range(0, 3)])
                                     : DIM_W'($urandom);
            load_query(HFLD_W'($urandom), d, rand_byte());
        end else begin
            load_coef(op, HFLD_W'($urandom), rand_coeff());
        end
    endtask

    // Long row of one repeated byte: drives head accumulators into their clamp
    task automatic pound_row(logic signed [BYTE_W-1:0] b);
        repeat (POUND_LEN) send_key(DIM_W'(key_dims[0]), b);
        send_key(DIM_W'(HEAD_DIM - 1), b);
    endtask

    // Result side: check on handshake, random stalls on i_ready
    initial begin
        i_ready  = 1'b0;
        out_hold = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_valid === 1'b1 && i_ready) scorer.check_score(o_score);
            if (out_hold > 0) begin
                out_hold--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 20) out_hold = pick_gap();
            end
        end
    end

    // Stimulus
    initial begin
        int unsigned r;
        scorer       = new();
        calm         = 1'b0;
        words_sent   = 0;
        rows_random  = 0;
        pound_rows   = 0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_op         = OP_QUERY;
        i_head       = '0;
        i_dim        = '0;
        i_byte_value = '0;
        i_coeff      = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every head needs its query bytes on the key dims, a scale and a weight
        foreach (key_dims[k]) begin
            for (int h = 0; h < HEADS; h++) begin
                load_query(HFLD_W'(h), DIM_W'(key_dims[k]), rand_byte());
            end
        end
        for (int h = 0; h < HEADS; h++) begin
            load_coef(OP_SCALE, HFLD_W'(h), rand_coeff());
            load_coef(OP_WEIGHT, HFLD_W'(h), rand_coeff());
        end

        // One head alone pushes the score past the top, then past the bottom
        load_query(HFLD_W'(5), DIM_W'(HEAD_DIM - 1), BYTE_BOT);
        load_coef(OP_SCALE, HFLD_W'(5), COEF_TOP);
        load_coef(OP_WEIGHT, HFLD_W'(5), COEF_TOP);
        send_key(DIM_W'(HEAD_DIM - 1), BYTE_BOT);
        load_coef(OP_WEIGHT, HFLD_W'(5), COEF_BOT);
        send_key(DIM_W'(HEAD_DIM - 1), BYTE_BOT);
        // Negative scale: the relu drops that head
        load_coef(OP_SCALE, HFLD_W'(5), COEF_BOT);
        send_key(DIM_W'(HEAD_DIM - 1), BYTE_BOT);
        // Multi-byte row with repeated dimension and extreme bytes
        load_query(HFLD_W'(0), DIM_W'(0), BYTE_TOP);
        load_query(HFLD_W'(1), DIM_W'(0), BYTE_BOT);
        load_query(HFLD_W'(63), DIM_W'(HEAD_DIM - 1), -8'sd127);
        send_key(DIM_W'(0), BYTE_TOP);
        send_key(DIM_W'(0), BYTE_BOT);
        send_key(DIM_W'(HEAD_DIM - 1), '0);
        // Zero scale and zero weight
        load_coef(OP_SCALE, HFLD_W'(63), '0);
        load_coef(OP_WEIGHT, HFLD_W'(0), '0);
        send_key(DIM_W'(HEAD_DIM - 1), BYTE_TOP);
        // Accumulators clamp in both directions
        pound_row(BYTE_BOT);

        // Random part: mostly rows, some load bursts, a few clamping rows
        while (words_sent < WORD_TARGET || rows_random < MIN_ROWS) begin
            if ($urandom_range(0, 19) == 0) calm = !calm;
            r = $urandom_range(0, 99);
            if (r < 70) begin
                repeat ($urandom_range(0, 6)) begin
                    if ($urandom_range(0, 9) == 0) random_load();
                    else send_key(DIM_W'(key_dims[$urandom_range(0, 2)]), rand_byte());
                end
                send_key(DIM_W'(HEAD_DIM - 1), rand_byte());
                rows_random++;
            end else if (r < 97 || pound_rows >= MAX_POUNDS) begin
                repeat ($urandom_range(1, 6)) random_load();
            end else begin
                pound_row($urandom_range(0, 1) ? BYTE_BOT : BYTE_TOP);
                pound_rows++;
                rows_random++;
            end
        end
        i_valid <= 1'b0;

        // Drain
        while (scorer.pending_scores.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("Covered %0d words in and %0d row scores out, %0d of them clamping rows.",
                 words_sent, scorer.scores_seen, pound_rows + 1);
        if (scorer.mismatches == 0 && scorer.pending_scores.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/iise_pkg.sv
design/iise_ram.sv
design/iise_head_mac.sv
design/iise_score_pipe.sv
design/int8_index_score_engine_core.sv
tb/sv/iise_tb_pkg.sv
tb/sv/tb_top.sv
